// ===== hdl/trace_record_deframer_core_assert.svh =====
// assertion macros for the trace record deframer
`ifndef TRACE_RECORD_DEFRAMER_CORE_ASSERT_SVH
`define TRACE_RECORD_DEFRAMER_CORE_ASSERT_SVH
// assertion that an implication holds at every edge out of reset
`define TRD_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// assertion that a condition implies something in the next cycle
`define TRD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/trd_pkg.sv =====
// ----------------------------------------------------------------------------
// trd_pkg
// types and constants shared by the trace record deframer modules
// ----------------------------------------------------------------------------
package trd_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC   = 3'd0,
    PH_HEADER  = 3'd1,
    PH_PAYLOAD = 3'd2,
    PH_DONE    = 3'd3,
    PH_ERROR   = 3'd4
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER = 3'd0,
    KIND_INPUT  = 3'd1,
    KIND_OUTPUT = 3'd2,
    KIND_END    = 3'd3,
    KIND_ERROR  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    ERR_MAGIC    = 3'd0,
    ERR_SHORT_HDR = 3'd1,
    ERR_SITE     = 3'd2,
    ERR_RESERVED = 3'd3,
    ERR_METADATA = 3'd4,
    ERR_SHORT_PAY = 3'd5,
    ERR_BAD_IN   = 3'd6,
    ERR_BAD_OUT  = 3'd7
  } err_t;

  // configuration register indexes
  localparam logic REG_MAX_COUNT    = 1'b0;
  localparam logic REG_MAX_POSITION = 1'b1;

  localparam int unsigned HDR_BYTES = 128;

  // header record carried with every header and payload result
  typedef struct packed {
    logic [31:0] layer;
    logic [31:0] head;
    logic [40:0] position;
    logic [24:0] rows;
    logic [24:0] columns;
    logic        causal_positive;
    logic [24:0] in_words;
    logic [24:0] out_words;
  } hdr_t;

  // classified byte handed from front to back
  typedef struct packed {
    kind_t      kind;
    err_t       code;
    logic       pass_hdr;   // header fields travel with the result
    logic [31:0] word;
    logic        last;
  } evt_t;

  // magic byte for position i
  function automatic logic [7:0] magic_byte(input logic [2:0] i);
    logic [7:0] r;
    unique case (i)
      3'd0: r = 8'h53;
      3'd1: r = 8'h4D;
      3'd2: r = 8'h54;
      3'd3: r = 8'h52;
      3'd4: r = 8'h43;
      3'd5: r = 8'h30;
      3'd6: r = 8'h30;
      default: r = 8'h31;
    endcase
    return r;
  endfunction

endpackage

// ===== hdl/trd_front.sv =====
// ----------------------------------------------------------------------------
// trd_front
// byte parser: magic, header fields, checks and payload word assembly
// ----------------------------------------------------------------------------
module trd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  input  logic               end_of_stream,
  input  logic [24:0]        max_count,
  input  logic [40:0]        max_position,
  input  logic               q_ready,
  output logic               q_valid,
  output trd_pkg::evt_t      q_evt,
  output trd_pkg::hdr_t      q_hdr
);
  import trd_pkg::*;

  phase_t      phase;
  logic [6:0]  byte_count;
  logic        magic_bad, site_term, site_bad, rsv_bad;
  logic [31:0] layer_reg, head_reg, rows_reg, columns_reg, causal_reg;
  logic [63:0] position_reg, in_words_reg, out_words_reg;
  logic [24:0] words_left;
  logic        in_out_sec;
  logic [23:0] word_bytes;
  logic [1:0]  byte_in_word;
  logic        bad_in, bad_out;
  // check pipeline: product and compares registered ahead of the last byte
  logic [63:0] prod;
  logic        meta_early_bad;

  logic        take;
  logic        hdr_last;
  logic [31:0] word;
  logic        nonfinite;
  logic [24:0] wl_dec;
  logic        meta_bad;
  logic        last_site_bad;

  assign in_ready = q_ready || (phase == PH_DONE) || (phase == PH_ERROR);
  assign take     = in_valid && in_ready;
  assign hdr_last = (byte_count == 7'(HDR_BYTES - 1));
  assign word     = {data_byte, word_bytes};
  assign nonfinite = (word[30:23] == 8'hFF);
  assign wl_dec   = (words_left != '0) ? words_left - 25'd1 : words_left;

  // limits compared live, so a register write just before the last byte counts
  assign meta_bad = meta_early_bad || (out_words_reg != prod) ||
                    position_reg > 64'(max_position) ||
                    in_words_reg > 64'(max_count) || out_words_reg > 64'(max_count);

  assign q_hdr.layer           = layer_reg;
  assign q_hdr.head            = head_reg;
  assign q_hdr.position        = position_reg[40:0];
  assign q_hdr.rows            = rows_reg[24:0];
  assign q_hdr.columns         = columns_reg[24:0];
  assign q_hdr.causal_positive = (causal_reg == 32'd1);
  assign q_hdr.in_words        = in_words_reg[24:0];
  assign q_hdr.out_words       = out_words_reg[24:0];

  assign last_site_bad = site_bad;

  always_comb begin
    q_valid = 1'b0;
    q_evt   = '{kind: KIND_HEADER, code: ERR_MAGIC, pass_hdr: 1'b0,
                word: 32'd0, last: 1'b0};
    if (in_valid) begin
      unique case (phase)
        PH_MAGIC: begin
          if (end_of_stream || (byte_count[2:0] == 3'd7 &&
              (magic_bad || data_byte != magic_byte(3'd7)))) begin
            q_valid    = 1'b1;
            q_evt.kind = KIND_ERROR;
            q_evt.code = ERR_MAGIC;
          end
        end
        PH_HEADER: begin
          if (end_of_stream) begin
            q_valid    = 1'b1;
            q_evt.kind = (byte_count == '0) ? KIND_END : KIND_ERROR;
            q_evt.code = (byte_count == '0) ? ERR_MAGIC : ERR_SHORT_HDR;
          end else if (hdr_last) begin
            q_valid = 1'b1;
            priority if (last_site_bad) begin
              q_evt.kind = KIND_ERROR; q_evt.code = ERR_SITE;
            end else if (rsv_bad || data_byte != 8'd0) begin
              q_evt.kind = KIND_ERROR; q_evt.code = ERR_RESERVED;
            end else if (meta_bad) begin
              q_evt.kind = KIND_ERROR; q_evt.code = ERR_METADATA;
            end else begin
              q_evt.kind = KIND_HEADER; q_evt.pass_hdr = 1'b1;
            end
          end
        end
        PH_PAYLOAD: begin
          if (end_of_stream) begin
            q_valid = 1'b1; q_evt.kind = KIND_ERROR; q_evt.code = ERR_SHORT_PAY;
          end else if (byte_in_word == 2'd3) begin
            q_valid = 1'b1;
            if (!in_out_sec) begin
              q_evt.kind = KIND_INPUT; q_evt.pass_hdr = 1'b1; q_evt.word = word;
            end else if (wl_dec != '0) begin
              q_evt.kind = KIND_OUTPUT; q_evt.pass_hdr = 1'b1; q_evt.word = word;
            end else if (bad_in) begin
              q_evt.kind = KIND_ERROR; q_evt.code = ERR_BAD_IN;
            end else if (bad_out || nonfinite) begin
              q_evt.kind = KIND_ERROR; q_evt.code = ERR_BAD_OUT;
            end else begin
              q_evt.kind = KIND_OUTPUT; q_evt.pass_hdr = 1'b1;
              q_evt.word = word; q_evt.last = 1'b1;
            end
          end
        end
        default: q_valid = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    prod <= 64'(rows_reg) * 64'(columns_reg);
    meta_early_bad <=
      (layer_reg[31] && layer_reg != '1) || (head_reg[31] && head_reg != '1) ||
      (causal_reg != 32'd1 && causal_reg != '1) ||
      rows_reg == '0 || columns_reg == '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_MAGIC;
      byte_count <= '0;
      magic_bad <= 1'b0; site_term <= 1'b0; site_bad <= 1'b0; rsv_bad <= 1'b0;
      layer_reg <= '0; head_reg <= '0; rows_reg <= '0; columns_reg <= '0;
      causal_reg <= '0; position_reg <= '0; in_words_reg <= '0;
      out_words_reg <= '0; words_left <= '0; in_out_sec <= 1'b0;
      word_bytes <= '0; byte_in_word <= '0; bad_in <= 1'b0; bad_out <= 1'b0;
    end else if (take) begin
      unique case (phase)
        PH_MAGIC: begin
          if (end_of_stream) phase <= PH_ERROR;
          else begin
            if (data_byte != magic_byte(byte_count[2:0])) magic_bad <= 1'b1;
            if (byte_count[2:0] == 3'd7) begin
              if (magic_bad || data_byte != magic_byte(3'd7)) phase <= PH_ERROR;
              else begin
                phase <= PH_HEADER; byte_count <= '0;
                site_term <= 1'b0; site_bad <= 1'b0; rsv_bad <= 1'b0;
                bad_in <= 1'b0; bad_out <= 1'b0;
              end
            end else byte_count <= byte_count + 7'd1;
          end
        end
        PH_HEADER: begin
          if (end_of_stream) phase <= (byte_count == '0) ? PH_DONE : PH_ERROR;
          else begin
            if (!hdr_last) byte_count <= byte_count + 7'd1;
            if (byte_count < 7'd64) begin
              if (site_term) begin
                if (data_byte != 8'd0) site_bad <= 1'b1;
              end else if (data_byte == 8'd0) begin
                if (byte_count == '0) site_bad <= 1'b1;
                site_term <= 1'b1;
              end
              if (byte_count == 7'd63 && !site_term && data_byte != 8'd0)
                site_bad <= 1'b1;
            end else if (byte_count < 7'd68)
              layer_reg[8*byte_count[1:0] +: 8] <= data_byte;
            else if (byte_count < 7'd72)
              head_reg[8*byte_count[1:0] +: 8] <= data_byte;
            else if (byte_count < 7'd80)
              position_reg[8*byte_count[2:0] +: 8] <= data_byte;
            else if (byte_count < 7'd84)
              rows_reg[8*byte_count[1:0] +: 8] <= data_byte;
            else if (byte_count < 7'd88)
              columns_reg[8*byte_count[1:0] +: 8] <= data_byte;
            else if (byte_count < 7'd92)
              causal_reg[8*byte_count[1:0] +: 8] <= data_byte;
            else if (byte_count < 7'd96) begin
              if (data_byte != 8'd0) rsv_bad <= 1'b1;
            end else if (byte_count < 7'd104)
              in_words_reg[8*byte_count[2:0] +: 8] <= data_byte;
            else if (byte_count < 7'd112)
              out_words_reg[8*byte_count[2:0] +: 8] <= data_byte;
            else if (data_byte != 8'd0) rsv_bad <= 1'b1;
            if (hdr_last) begin
              if (q_evt.kind == KIND_ERROR) phase <= PH_ERROR;
              else begin
                phase <= PH_PAYLOAD; byte_count <= '0;
                byte_in_word <= '0; word_bytes <= '0;
                if (in_words_reg != '0) begin
                  in_out_sec <= 1'b0; words_left <= in_words_reg[24:0];
                end else begin
                  in_out_sec <= 1'b1; words_left <= out_words_reg[24:0];
                end
              end
            end
          end
        end
        PH_PAYLOAD: begin
          if (end_of_stream) phase <= PH_ERROR;
          else if (byte_in_word != 2'd3) begin
            word_bytes[8*byte_in_word +: 8] <= data_byte;
            byte_in_word <= byte_in_word + 2'd1;
          end else begin
            word_bytes <= '0; byte_in_word <= '0;
            if (!in_out_sec) begin
              if (nonfinite) bad_in <= 1'b1;
              if (wl_dec == '0) begin
                in_out_sec <= 1'b1; words_left <= out_words_reg[24:0];
              end else words_left <= wl_dec;
            end else begin
              words_left <= wl_dec;
              if (nonfinite) bad_out <= 1'b1;
              if (wl_dec == '0) begin
                if (q_evt.kind == KIND_ERROR) phase <= PH_ERROR;
                else begin
                  phase <= PH_HEADER; byte_count <= '0;
                  site_term <= 1'b0; site_bad <= 1'b0; rsv_bad <= 1'b0;
                  bad_in <= 1'b0; bad_out <= 1'b0;
                end
              end
            end
          end
        end
        default: phase <= phase;
      endcase
    end
  end
endmodule

// ===== hdl/trd_back.sv =====
// ----------------------------------------------------------------------------
// trd_back
// two-entry result queue and output formatting
// ----------------------------------------------------------------------------
module trd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  output logic           q_ready,
  input  trd_pkg::evt_t  q_evt,
  input  trd_pkg::hdr_t  q_hdr,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [247:0]   out_data,
  output logic [7:0]     out_user
);
  import trd_pkg::*;

  typedef struct packed {
    evt_t evt;
    hdr_t hdr;
  } ent_t;

  ent_t       mem [2];
  logic       wp, rp;
  logic [1:0] cnt;
  logic       push, pop;
  ent_t       e;
  hdr_t       h;

  assign q_ready   = (cnt != 2'd2);
  assign push      = q_valid && q_ready;
  assign out_valid = (cnt != 2'd0);
  assign pop       = out_valid && out_ready;
  assign e         = mem[rp];
  assign h         = e.evt.pass_hdr ? e.hdr : '0;

  // tdata: error_code, layer, head, position, rows, columns, causal_positive,
  // in_words, out_words, payload_word, last
  assign out_data = {6'd0, e.evt.last, e.evt.word, h.out_words, h.in_words,
                     h.causal_positive, h.columns, h.rows, h.position,
                     h.head, h.layer, (e.evt.kind == KIND_ERROR) ? e.evt.code : ERR_MAGIC};
  assign out_user = {5'd0, e.evt.kind};

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= '{evt: q_evt, hdr: q_hdr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + 2'(push) - 2'(pop);
    end
  end
endmodule

// ===== hdl/trace_record_deframer_core.sv =====
// ----------------------------------------------------------------------------
// trace_record_deframer_core
// byte stream deframer for trace records with header checks
// ----------------------------------------------------------------------------
// One byte is taken per cycle while the two-entry result queue has room; a
// result enters that queue on its last byte. Header metadata checks use the
// registered row-column product, so the header's final bytes cost no stall.
// After a clean end or error the input keeps draining with no results.
module trace_record_deframer_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic [7:0]   s_axis_tuser,   // end_of_stream, zero fill
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [247:0] m_axis_tdata,   // error_code, layer, head, position, rows,
                                       // columns, causal_positive, in_words,
                                       // out_words, payload_word, last, zero fill
  output logic [7:0]   m_axis_tuser,   // kind, zero fill
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [40:0]  cfg_data
);
  import trd_pkg::*;

  logic [24:0] max_count;
  logic [40:0] max_position;
  logic        q_valid, q_ready;
  evt_t        q_evt;
  hdr_t        q_hdr;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_count    <= 25'd16777216;
      max_position <= 41'h100_0000_0000;
    end else if (cfg_we) begin
      if (cfg_index == REG_MAX_COUNT) max_count <= cfg_data[24:0];
      else max_position <= cfg_data;
    end
  end

  trd_front u_front (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .data_byte(s_axis_tdata), .end_of_stream(s_axis_tuser[0]),
    .max_count, .max_position,
    .q_ready, .q_valid, .q_evt, .q_hdr
  );

  trd_back u_back (
    .clk, .rst, .q_valid, .q_ready, .q_evt, .q_hdr,
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .out_data(m_axis_tdata), .out_user(m_axis_tuser)
  );
endmodule

// ===== hdl/trd_checker.sv =====
// ----------------------------------------------------------------------------
// trd_checker
// port-level checks bound to the deframer top level
// ----------------------------------------------------------------------------
`include "trace_record_deframer_core_assert.svh"
module trd_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [247:0] m_axis_tdata,
  input logic [7:0]   m_axis_tuser
);
  import trd_pkg::*;

  `TRD_ASSERT(a_kind_range, m_axis_tvalid, m_axis_tuser[2:0] <= KIND_ERROR, "bad kind")
  `TRD_ASSERT(a_code_zero, m_axis_tvalid && m_axis_tuser[2:0] != KIND_ERROR, m_axis_tdata[2:0] == ERR_MAGIC, "code without error")
  `TRD_ASSERT(a_last_kind, m_axis_tvalid && m_axis_tdata[241], m_axis_tuser[2:0] == KIND_OUTPUT, "last on non output")
  `TRD_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
endmodule

bind trace_record_deframer_core trd_checker u_trd_checker (.*);
